[design/avi_riff_frame_indexer_defines.svh]
// Assertion macros used by the top-level design file
`ifndef AVI_RIFF_FRAME_INDEXER_DEFINES_SVH
`define AVI_RIFF_FRAME_INDEXER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define AFI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define AFI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/afi_pkg.sv]
package afi_pkg;

	typedef enum logic [3:0] {
		PH_FILEHDR, PH_TOP_GAP, PH_TOP_HDR, PH_LIST_TYPE, PH_SUB_GAP,
		PH_SUB_HDR, PH_END, PH_BAD, PH_FINISHED
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0, KIND_HEADER = 2'd1, KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_BAD = 2'd1, ST_NOFRAMES = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		LK_NONE = 2'd0, LK_HDRL = 2'd1, LK_MOVI = 2'd2, LK_OTHER = 2'd3
	} listk_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_AVI  = 32'h2049_5641;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_HDRL = 32'h6C72_6468;
	localparam logic [31:0] TAG_MOVI = 32'h6976_6F6D;
	localparam logic [31:0] TAG_AVIH = 32'h6869_7661;
	localparam logic [31:0] TAG_00DC = 32'h6364_3030;
	localparam logic [31:0] TAG_00DB = 32'h6264_3030;
	localparam logic [19:0] FPS_NUM     = 20'd1000000;
	localparam logic [19:0] FPS_DEFAULT = 20'd15;
	localparam logic [32:0] AVIH_MIN    = 33'd56;
	localparam int          FRAME_CAP   = 1000;

	// One output record; last flag is appended by the top level
	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  num;
		logic [31:0] off;
		logic [31:0] len;
		logic        inf;
		logic [31:0] w;
		logic [31:0] h;
		logic [19:0] fps;
		logic [1:0]  st;
	} rec_t;

	// Request to the divider and its answer
	typedef struct packed {
		logic        start;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [19:0] quo;
	} div_rsp_t;

endpackage

[design/afi_div.sv]
// Radix-2 restoring divider: 1000000 / den, one quotient bit per cycle
module afi_div
	import afi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [19:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] trial;

	// shift in the next dividend bit and try subtracting
	always_comb begin
		trial = {rem_q[31:0], FPS_NUM[cnt_q]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd19;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[18:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[18:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

[design/avi_riff_frame_indexer.sv]
// A byte's records are written to the output queue when it is processed; a byte that
//   completes an avih capture with nonzero usec is first held while the bit-serial
//   divider computes fps. Its records (up to three) leave one per cycle while m_tready is high.
// Throughput: one byte per cycle while no records are queued and no divide is
//   pending; a new byte waits until the queue has drained and the divide is done.
// Reset (arst_n low): all parser state, file_length and the queue clear.
module avi_riff_frame_indexer
	import afi_pkg::*;
#(
	parameter int MAX_FRAMES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // file_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] frame_number, [41:10] frame_offset, [73:42] frame_length,
	// [74] frame_in_file, [106:75] video_width, [138:107] video_height,
	// [158:139] frames_per_second, [160:159] done_status, zero fill to 167
	output logic [167:0] m_tdata,
	output logic [1:0]  m_tuser,     // record_kind
	output logic        m_tlast      // last_of_run
);
	`include "avi_riff_frame_indexer_defines.svh"

	localparam int LIMIT = (MAX_FRAMES < FRAME_CAP) ? MAX_FRAMES : FRAME_CAP;

	phase_t      ph_q;
	logic [32:0] pos_q, left_q, lend_q;
	logic [63:0] hs_q;
	listk_t      lk_q;
	logic [10:0] nfr_q;
	logic [31:0] usec_q, wid_q, hgt_q, flen_q;
	logic [32:0] cbase_q;
	logic        cval_q, stop_q;

	// output queue; it only ever holds the records of one byte
	rec_t        q_rec_q [3];
	logic [1:0]  q_cnt_q;

	// held byte waiting on the divider
	logic        wait_q;
	logic [7:0]  hold_q;

	div_req_t    dreq;
	div_rsp_t    drsp;

	afi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [7:0]  v;
	logic        go;
	logic        cap_fire;
	logic [32:0] coff;
	logic [31:0] usec_n;

	// Byte processing combinational results
	phase_t      ph_n;
	logic [32:0] left_n, lend_n;
	logic [63:0] hs_n;
	listk_t      lk_n;
	logic [10:0] nfr_n;
	logic [31:0] wid_n, hgt_n;
	logic [32:0] cbase_n;
	logic        cval_n, stop_n;
	rec_t        r_hdr, r_frm, r_done;
	logic        e_hdr, e_frm, e_done;
	logic [32:0] p, cs, flen33, b;
	logic [31:0] id, ty;
	logic [33:0] sum34;
	logic        walk;

	assign v      = wait_q ? hold_q : s_tdata;
	assign flen33 = {1'b0, flen_q};
	assign b      = pos_q;
	assign coff   = pos_q - cbase_q;
	assign cap_fire = cval_q && (pos_q >= cbase_q) && (coff >= 33'd39);

	// usec after this byte's capture
	always_comb begin
		usec_n = usec_q;
		if (cval_q && pos_q >= cbase_q && coff < 33'd4)
			usec_n = usec_q | ({24'd0, v} << {coff[1:0], 3'b000});
	end

	// a byte is accepted when queue empty and no divide pending
	assign s_tready = (q_cnt_q == 2'd0) && !wait_q && !drsp.busy && !drsp.done;
	assign cfg_ready = 1'b1;
	// process now: plain byte, or held byte once quotient is ready
	assign go = (s_tvalid && s_tready && !(cap_fire && usec_n != 32'd0 &&
		ph_q != PH_FINISHED)) || (wait_q && drsp.done);

	assign dreq.start = s_tvalid && s_tready && cap_fire && usec_n != 32'd0 &&
		ph_q != PH_FINISHED;
	assign dreq.den   = usec_n;

	// Parser step: phase walk with at most three internal hops
	always_comb begin
		ph_n = ph_q; left_n = left_q; lend_n = lend_q; hs_n = hs_q; lk_n = lk_q;
		nfr_n = nfr_q; wid_n = wid_q; hgt_n = hgt_q; cbase_n = cbase_q;
		cval_n = cval_q; stop_n = stop_q;
		e_hdr = 1'b0; e_frm = 1'b0; e_done = 1'b0;
		r_hdr = '0; r_frm = '0; r_done = '0;
		p = '0; cs = '0; id = '0; ty = '0; sum34 = '0;
		walk = 1'b1;

		// capture
		if (cval_q && pos_q >= cbase_q) begin
			if (coff >= 33'd32 && coff < 33'd36)
				wid_n = wid_q | ({24'd0, v} << {coff[1:0], 3'b000});
			else if (coff >= 33'd36 && coff < 33'd40)
				hgt_n = hgt_q | ({24'd0, v} << {coff[1:0], 3'b000});
			if (coff >= 33'd39) begin
				e_hdr = 1'b1;
				r_hdr.kind = KIND_HEADER;
				r_hdr.w = wid_n;
				r_hdr.h = hgt_n;
				r_hdr.fps = (usec_n == 32'd0) ? FPS_DEFAULT : drsp.quo;
				cval_n = 1'b0;
			end
		end

		for (int it = 0; it < 3; it++) begin
			if (walk) begin
				case (ph_n)
					PH_FILEHDR: begin
						hs_n = {v, hs_n[63:8]};
						if (b == 33'd3 && hs_n[63:32] != TAG_RIFF) ph_n = PH_BAD;
						else if (b == 33'd11) begin
							if (hs_n[63:32] == TAG_AVI) begin
								ph_n = PH_TOP_GAP; left_n = '0;
							end else ph_n = PH_BAD;
						end
						walk = 1'b0;
					end
					PH_TOP_GAP: begin
						if (left_n != '0) begin
							left_n = left_n - 33'd1; walk = 1'b0;
						end else if ({1'b0, b} + 34'd8 <= {1'b0, flen33}) begin
							ph_n = PH_TOP_HDR; left_n = 33'd8;
						end else begin
							ph_n = PH_END; walk = 1'b0;
						end
					end
					PH_SUB_GAP: begin
						if (b >= lend_n) begin
							ph_n = PH_TOP_GAP; left_n = '0;
						end else if (left_n != '0) begin
							left_n = left_n - 33'd1; walk = 1'b0;
						end else if ({1'b0, b} + 34'd8 < {1'b0, lend_n}) begin
							ph_n = PH_SUB_HDR; left_n = 33'd8;
						end else begin
							// burns rest of list: one byte now, rest counted
							left_n = lend_n - b - 33'd1; walk = 1'b0;
						end
					end
					PH_TOP_HDR, PH_LIST_TYPE, PH_SUB_HDR: begin
						hs_n = {v, hs_n[63:8]};
						left_n = left_n - 33'd1;
						walk = 1'b0;
						if (left_n == '0) begin
							p  = b - 33'd7;
							id = hs_n[31:0];
							cs = {1'b0, hs_n[63:32]};
							ty = hs_n[63:32];
							if (ph_n == PH_TOP_HDR) begin
								sum34 = {1'b0, p} + 34'd8;
								if (sum34 > {1'b0, flen33} ||
									{1'b0, cs} > {1'b0, flen33} - sum34) begin
									ph_n = PH_END; stop_n = 1'b1;
								end else if (id == TAG_LIST) begin
									if (cs < 33'd4) begin
										if ({1'b0, p} + 34'd12 > {1'b0, flen33})
											ph_n = PH_END;
										else begin
											left_n = cs; ph_n = PH_TOP_GAP;
										end
									end else begin
										lend_n = p + 33'd8 + cs;
										left_n = 33'd4; ph_n = PH_LIST_TYPE;
									end
								end else begin
									left_n = cs + {32'd0, p[0] ^ cs[0]};
									ph_n = PH_TOP_GAP;
								end
							end else if (ph_n == PH_LIST_TYPE) begin
								if (ty == TAG_HDRL) lk_n = LK_HDRL;
								else if (ty == TAG_MOVI) lk_n = LK_MOVI;
								else lk_n = LK_OTHER;
								if (lk_n == LK_OTHER) begin
									left_n = lend_n - b - 33'd1; ph_n = PH_TOP_GAP;
								end else begin
									left_n = '0; ph_n = PH_SUB_GAP;
								end
							end else begin
								if (lk_q == LK_HDRL && id == TAG_AVIH && cs >= AVIH_MIN) begin
									cval_n = 1'b1; cbase_n = p + 33'd8;
									wid_n = '0; hgt_n = '0;
								end
								if (lk_q == LK_MOVI && (id == TAG_00DC || id == TAG_00DB) &&
									nfr_q < 11'(LIMIT)) begin
									e_frm = 1'b1;
									r_frm.kind = KIND_FRAME;
									r_frm.num = nfr_q[9:0];
									r_frm.off = 32'(p + 33'd8);
									r_frm.len = cs[31:0];
									r_frm.inf = ({1'b0, p} + 34'd8 + {1'b0, cs}) <=
										{1'b0, flen33};
									nfr_n = nfr_q + 11'd1;
								end
								left_n = cs + {32'd0, p[0] ^ cs[0]};
								if (left_n > lend_n - b - 33'd1)
									left_n = lend_n - b - 33'd1;
								ph_n = PH_SUB_GAP;
							end
						end
					end
					default: walk = 1'b0;
				endcase
			end
		end

		// file end
		if (b + 33'd1 >= flen33) begin
			e_done = 1'b1;
			r_done.kind = KIND_DONE;
			r_done.num = nfr_n[9:0];
			if (flen_q < 32'd12 || ph_n == PH_FILEHDR || ph_n == PH_BAD)
				r_done.st = ST_BAD;
			else if (nfr_n == '0) r_done.st = ST_NOFRAMES;
			else r_done.st = ST_OK;
			ph_n = PH_FINISHED;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_FILEHDR; pos_q <= '0; left_q <= '0; lend_q <= '0;
			hs_q <= '0; lk_q <= LK_NONE; nfr_q <= '0; usec_q <= '0;
			wid_q <= '0; hgt_q <= '0; cbase_q <= '0; cval_q <= 1'b0;
			stop_q <= 1'b0; flen_q <= '0; wait_q <= 1'b0; hold_q <= '0;
			q_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) flen_q <= cfg_data;
			if (dreq.start) begin
				wait_q <= 1'b1; hold_q <= s_tdata;
			end
			if (q_cnt_q != 2'd0 && m_tready) begin
				q_rec_q[0] <= q_rec_q[1];
				q_rec_q[1] <= q_rec_q[2];
				q_cnt_q <= q_cnt_q - 2'd1;
			end
			if (go) begin
				wait_q <= 1'b0;
				if (ph_q != PH_FINISHED) begin
					ph_q <= ph_n; left_q <= left_n; lend_q <= lend_n; hs_q <= hs_n;
					lk_q <= lk_n; nfr_q <= nfr_n; usec_q <= cval_n ? usec_n : usec_n;
					wid_q <= wid_n; hgt_q <= hgt_n; cbase_q <= cbase_n;
					cval_q <= cval_n; stop_q <= stop_n;
					if (cval_n && !cval_q) usec_q <= '0;
					else if (cval_n && cbase_n != cbase_q) usec_q <= '0;
					// queue is empty here; fill in order header, frame, done
					q_rec_q[0] <= e_hdr ? r_hdr : (e_frm ? r_frm : r_done);
					q_rec_q[1] <= (e_hdr && e_frm) ? r_frm : r_done;
					q_rec_q[2] <= r_done;
					q_cnt_q <= 2'({1'b0, e_hdr} + {1'b0, e_frm} + {1'b0, e_done});
				end
				pos_q <= pos_q + 33'd1;
			end
		end
	end

	assign m_tvalid = q_cnt_q != 2'd0;
	assign m_tuser  = q_rec_q[0].kind;
	assign m_tlast  = q_cnt_q == 2'd1;
	assign m_tdata  = {7'd0, q_rec_q[0].st, q_rec_q[0].fps, q_rec_q[0].h,
		q_rec_q[0].w, q_rec_q[0].inf, q_rec_q[0].len, q_rec_q[0].off, q_rec_q[0].num};

	`AFI_ASSERT_IMP(a_no_accept_busy, drsp.busy, !s_tready, "accept during divide")
	`AFI_ASSERT_IMP(a_q_blocks, m_tvalid, !s_tready, "accept while records queued")
	`AFI_ASSERT_NXT(a_div_held, dreq.start, wait_q, "divide without held byte")
	`AFI_ASSERT_IMP(a_fin_stays, $past(ph_q) == PH_FINISHED && $past(arst_n),
		ph_q == PH_FINISHED, "finished phase left")

endmodule
